>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_SCF(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

>>> sv/scf_pkg.sv
package scf_pkg;

	// Default geometry of the queue
	localparam int SCF_DEPTH      = 16;
	localparam int SCF_DATA_WIDTH = 32;

	// Fixed port widths of the data fields, and the widened word used for zero extension
	localparam int DATA_IO_W = 32;
	localparam int WIDE_W    = 64;

	// Command codes on the command port
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified operation
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	// Command handed from front to back
	typedef struct packed {
		op_t                  op;
		logic [DATA_IO_W-1:0] data;
	} cmd_t;

endpackage

>>> sv/scf_front.sv
module scf_front
	import scf_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [1:0]                  command,
	input  logic signed [DATA_IO_W-1:0] data_in,
	output logic                        fb_valid,
	input  logic                        fb_ready,
	output cmd_t                        fb_cmd
);

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cls_cmd;
	logic              push;
	logic              pop;

	// Classify the incoming command
	always_comb begin
		cls_cmd.data = data_in;
		case (command)
			CMD_ADD:    cls_cmd.op = OP_ADD;
			CMD_DELETE: cls_cmd.op = OP_DELETE;
			CMD_SEARCH: cls_cmd.op = OP_SEARCH;
			default:    cls_cmd.op = OP_IGNORE;
		endcase
	end

	assign cmd_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign fb_valid  = (cnt_q != '0);
	assign pop       = fb_valid && fb_ready;
	assign fb_cmd    = ent_q[rd_ptr_q];

	// Hold classified commands until the back takes them
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls_cmd;
		end
	end

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/scf_back.sv
module scf_back
	import scf_pkg::*;
#(
	parameter int DEPTH      = SCF_DEPTH,
	parameter int DATA_WIDTH = SCF_DATA_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fb_valid,
	output logic                            fb_ready,
	input  cmd_t                            fb_cmd,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic signed [DATA_IO_W-1:0]     data_out,
	output logic                            found,
	output logic [$clog2(DEPTH+1)-1:0]      found_slot,
	output logic [$clog2(DEPTH+1)-1:0]      entry_count,
	output logic                            is_empty,
	output logic                            is_full,
	output logic                            refused
);

	localparam int SLOT_W = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEL  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [SLOT_W-1:0]     head_q;
	logic [SLOT_W-1:0]     tail_q;
	logic [SLOT_W-1:0]     count_q;
	logic [SLOT_W-1:0]     iss_slot_q;
	logic [SLOT_W-1:0]     rd_slot_q;
	logic [SLOT_W-1:0]     left_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DATA_IO_W-1:0]  data_out_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     fslot_q;
	logic                  refused_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  mem_we;
	logic                  mem_re;
	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     raddr;
	logic [WIDE_W-1:0]     wide_in;
	logic [WIDE_W-1:0]     wide_out;
	logic [DATA_WIDTH-1:0] value;
	logic [SLOT_W-1:0]     new_tail;
	logic                  q_full;
	logic                  q_empty;
	logic                  match;

	// Slot after s, wrapping from DEPTH back to 1
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s >= SLOT_W'(DEPTH)) ? SLOT_W'(1) : s + SLOT_W'(1);
	endfunction

	assign wide_in  = WIDE_W'(fb_cmd.data);
	assign value    = wide_in[DATA_WIDTH-1:0];
	assign wide_out = WIDE_W'(rdata_q);
	assign q_full   = (count_q == SLOT_W'(DEPTH));
	assign q_empty  = (count_q == '0);
	assign new_tail = (head_q == '0) ? SLOT_W'(1) : next_slot(tail_q);
	assign match    = (rdata_q == key_q);
	assign fb_ready = (state_q == ST_IDLE);

	// Drive the slot memory ports
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = ADDR_W'(new_tail - SLOT_W'(1));
		raddr  = ADDR_W'(head_q - SLOT_W'(1));
		case (state_q)
			ST_IDLE: begin
				if (fb_valid) begin
					case (fb_cmd.op)
						OP_ADD:    mem_we = !q_full;
						OP_DELETE: mem_re = !q_empty;
						OP_SEARCH: mem_re = !q_empty;
						default:   ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!match && (left_q != '0)) begin
					mem_re = 1'b1;
					raddr  = ADDR_W'(iss_slot_q - SLOT_W'(1));
				end
			end
			default: ;
		endcase
	end

	// Slot memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= value;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Execute commands and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			iss_slot_q <= '0;
			rd_slot_q  <= '0;
			left_q     <= '0;
			key_q      <= '0;
			data_out_q <= '0;
			found_q    <= 1'b0;
			fslot_q    <= '0;
			refused_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fb_valid) begin
						data_out_q <= '0;
						found_q    <= 1'b0;
						fslot_q    <= '0;
						refused_q  <= 1'b0;
						state_q    <= ST_OUT;
						case (fb_cmd.op)
							OP_ADD: begin
								if (q_full) begin
									refused_q <= 1'b1;
								end else begin
									if (head_q == '0) begin
										head_q <= SLOT_W'(1);
									end
									tail_q  <= new_tail;
									count_q <= count_q + SLOT_W'(1);
								end
							end
							OP_DELETE: begin
								if (q_empty) begin
									refused_q <= 1'b1;
								end else begin
									state_q <= ST_DEL;
									if (head_q == tail_q) begin
										head_q <= '0;
										tail_q <= '0;
									end else begin
										head_q <= next_slot(head_q);
									end
									count_q <= count_q - SLOT_W'(1);
								end
							end
							OP_SEARCH: begin
								if (!q_empty) begin
									state_q    <= ST_SCAN;
									key_q      <= value;
									rd_slot_q  <= head_q;
									iss_slot_q <= next_slot(head_q);
									left_q     <= count_q - SLOT_W'(1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_DEL: begin
					// Pick up the head word read on the way in
					data_out_q <= wide_out[DATA_IO_W-1:0];
					state_q    <= ST_OUT;
				end
				ST_SCAN: begin
					// Compare one slot per cycle while the next read is in flight
					if (match) begin
						found_q <= 1'b1;
						fslot_q <= rd_slot_q;
						state_q <= ST_OUT;
					end else if (left_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						rd_slot_q  <= iss_slot_q;
						iss_slot_q <= next_slot(iss_slot_q);
						left_q     <= left_q - SLOT_W'(1);
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid   = (state_q == ST_OUT);
	assign data_out    = data_out_q;
	assign found       = found_q;
	assign found_slot  = fslot_q;
	assign entry_count = count_q;
	assign is_empty    = q_empty;
	assign is_full     = q_full;
	assign refused     = refused_q;

endmodule

>>> sv/searchable_circular_fifo.sv
// Searchable circular FIFO of DEPTH words in slots 1..DEPTH. Each command (add, delete,
// search) yields exactly one result with the status after the command; an add on a full
// queue or a delete on an empty one is refused and flagged. A two-entry command queue
// accepts new commands while the execution side works. An add, a refused command or an
// ignored code goes from idle straight to the result state; a delete passes through a
// state that picks up the head word read on the way in; a search on a nonempty queue
// compares the entries from the head until a match or the last entry. The slot memory's
// single registered read port sets the scan at one slot per cycle, and one command is
// executed at a time.
module searchable_circular_fifo
	import scf_pkg::*;
#(
	parameter int DEPTH      = SCF_DEPTH,
	parameter int DATA_WIDTH = SCF_DATA_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [1:0]                      command,
	input  logic signed [DATA_IO_W-1:0]     data_in,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic signed [DATA_IO_W-1:0]     data_out,
	output logic                            found,
	output logic [$clog2(DEPTH+1)-1:0]      found_slot,
	output logic [$clog2(DEPTH+1)-1:0]      entry_count,
	output logic                            is_empty,
	output logic                            is_full,
	output logic                            refused
);

	logic fb_valid;
	logic fb_ready;
	cmd_t fb_cmd;

	// Accept and classify commands
	scf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.data_in   (data_in),
		.fb_valid  (fb_valid),
		.fb_ready  (fb_ready),
		.fb_cmd    (fb_cmd)
	);

	// Execute commands against the slot memory
	scf_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fb_valid    (fb_valid),
		.fb_ready    (fb_ready),
		.fb_cmd      (fb_cmd),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.data_out    (data_out),
		.found       (found),
		.found_slot  (found_slot),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.refused     (refused)
	);

endmodule

>>> sv/scf_checker.sv
`include "assert_macros.svh"

module scf_checker
	import scf_pkg::*;
#(
	parameter int DEPTH = SCF_DEPTH
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [DATA_IO_W-1:0]        data_out,
	input logic                        found,
	input logic [$clog2(DEPTH+1)-1:0]  found_slot,
	input logic [$clog2(DEPTH+1)-1:0]  entry_count,
	input logic                        is_empty,
	input logic                        is_full,
	input logic                        refused
);

	localparam int SLOT_W = $clog2(DEPTH + 1);

	// Hold a stalled result transaction
	`ASSERT_SCF(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(data_out) && $stable(found_slot), "result changed while stalled")

	// Refuse only at a boundary of the queue
	`ASSERT_SCF(a_refuse_bound, res_valid && refused |-> is_full || is_empty, "refused away from full or empty")

	// Report a hit only with a valid slot in a nonempty queue
	`ASSERT_SCF(a_found_slot, res_valid && found |-> found_slot != '0 && found_slot <= SLOT_W'(DEPTH) && !is_empty, "bad found slot")

	// Keep full flag and count in step
	`ASSERT_SCF(a_full_count, res_valid |-> is_full == (entry_count == SLOT_W'(DEPTH)), "full flag disagrees with count")

endmodule

bind searchable_circular_fifo scf_checker #(.DEPTH(DEPTH)) u_scf_checker (.*);
